[rtl/assert_macros.svh]
// Assertion macros for the RTL modules of the coefficient unit, used by the controller.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside of reset.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: assertion failed");

// Condition must never be true at a rising clock edge outside of reset.
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("%m: forbidden condition seen");

`endif

[rtl/mca_pkg.sv]
// Shared types and constants of the modular coefficient unit.
// Used by the controller, the datapath and the top level; no dependencies.
package mca_pkg;

   // Field and register widths.
   localparam int CoeffW    = 63;
   localparam int ModW      = 62;
   localparam int WideW     = 64;
   localparam int CntW      = 6;
   localparam int ReqDataW  = 128;
   localparam int RspDataW  = 64;
   localparam int KindW     = 2;

   // Modulus value after reset.
   localparam logic [ModW-1:0] ModulusReset = 62'd549824583172097;

   // Operation codes carried on the request tuser.
   typedef enum logic [KindW-1:0] {
      KIND_REDUCE = 2'd0,
      KIND_ADD    = 2'd1,
      KIND_SUB    = 2'd2,
      KIND_NORM   = 2'd3
   } kind_type;

   // Controller states, one-hot.
   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_PREP = 7'b0000010,
      ST_ABS  = 7'b0000100,
      ST_DIV  = 7'b0001000,
      ST_FIX  = 7'b0010000,
      ST_NORM = 7'b0100000,
      ST_EMIT = 7'b1000000
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic prep;
      logic abs_val;
      logic div_step;
      logic fix;
      logic norm;
      logic emit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_norm;
      logic div_last;
      logic out_free;
   } sts_type;

endpackage

[rtl/modq_coeff_alu_with_norm.sv]
// Reduce, add and subtract pass through acceptance, preparation, magnitude, 64 steps of the
// one-bit-per-cycle restoring divider, correction and hand-off.
// A norm step bypasses the divider: acceptance, preparation, magnitude, norm update and hand-off.
// The result register lets a new request be accepted while a result awaits its transfer.
// Synchronous active-high reset sets the modulus to 549824583172097, clears the running
// maximum and drops any pending result.
module modq_coeff_alu_with_norm (
   input  logic                           clock,
   input  logic                           reset,
   // Request channel.
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [mca_pkg::ReqDataW-1:0]   req_tdata,  // coeff_a [62:0], coeff_b [125:63], zero pad
   input  logic [mca_pkg::KindW-1:0]      req_tuser,  // kind [1:0]
   input  logic                           req_tlast,
   // Response channel.
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [mca_pkg::RspDataW-1:0]   rsp_tdata,  // value [62:0], zero pad
   output logic                           rsp_tlast,
   // Modulus register write port.
   input  logic                           csr_we,
   input  logic [mca_pkg::ModW-1:0]       csr_wdata
);
   import mca_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Sequencing.
   mca_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Arithmetic and result storage.
   mca_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

[rtl/mca_datapath.sv]
// Datapath of the modular coefficient unit: operand registers, the serial
// restoring divider, norm tracking and the result register. Uses mca_pkg.
module mca_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [mca_pkg::ReqDataW-1:0]   req_tdata,
   input  logic [mca_pkg::KindW-1:0]      req_tuser,
   input  logic                           req_tlast,
   input  logic                           csr_we,
   input  logic [mca_pkg::ModW-1:0]       csr_wdata,
   input  mca_pkg::cmd_type               cmd,
   output mca_pkg::sts_type               sts,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [mca_pkg::RspDataW-1:0]   rsp_tdata,
   output logic                           rsp_tlast
);
   import mca_pkg::*;

   logic [ModW-1:0]          mod_ff;
   kind_type                 kind_ff;
   logic [CoeffW-1:0]        a_ff;
   logic [CoeffW-1:0]        b_ff;
   logic                     last_ff;
   logic signed [WideW-1:0]  s_ff;
   logic signed [WideW-1:0]  s_in;
   logic [WideW-1:0]         mag_ff;
   logic [WideW-1:0]         mag_in;
   logic                     neg_ff;
   logic [ModW-1:0]          rem_ff;
   logic [ModW-1:0]          rem_in;
   logic [CntW-1:0]          cnt_ff;
   logic [CoeffW-1:0]        res_ff;
   logic [CoeffW-1:0]        max_ff;
   logic [CoeffW-1:0]        max_in;
   logic                     rsp_valid_ff;
   logic [CoeffW-1:0]        rsp_value_ff;
   logic                     rsp_last_ff;

   logic signed [WideW-1:0]  a_wide;
   logic signed [WideW-1:0]  b_wide;
   logic signed [WideW-1:0]  q_wide;
   logic signed [WideW-1:0]  half_wide;
   logic [ModW:0]            rem_shift;
   logic [ModW:0]            q_ext;
   logic [ModW:0]            rem_diff;
   logic [ModW-1:0]          fix_val;
   logic [CoeffW-1:0]        mag_narrow;

   // Modulus register, written through the configuration port.
   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ff <= ModulusReset;
      end else if (csr_we) begin
         mod_ff <= csr_wdata;
      end
   end

   // Capture the operands of an accepted request transfer.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= kind_type'(req_tuser);
         a_ff    <= req_tdata[CoeffW-1:0];
         b_ff    <= req_tdata[2*CoeffW-1:CoeffW];
         last_ff <= req_tlast;
      end
   end

   // Sign-extend operands and form the centering threshold floor(q/2).
   assign a_wide    = {a_ff[CoeffW-1], a_ff};
   assign b_wide    = {b_ff[CoeffW-1], b_ff};
   assign q_wide    = {{(WideW-ModW){1'b0}}, mod_ff};
   assign half_wide = {{(WideW-ModW+1){1'b0}}, mod_ff[ModW-1:1]};

   // The operand, or the exact sum, difference or centered value, in 64 bits.
   always_comb begin
      case (kind_ff)
         KIND_REDUCE: s_in = a_wide;
         KIND_ADD:    s_in = a_wide + b_wide;
         KIND_SUB:    s_in = a_wide - b_wide;
         KIND_NORM:   s_in = (a_wide > half_wide) ? (a_wide - q_wide) : a_wide;
         default:     s_in = a_wide;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         s_ff <= s_in;
      end
   end

   // Magnitude and sign of the prepared value.
   assign mag_in = s_ff[WideW-1] ? (WideW'(0) - s_ff) : s_ff;

   // One restoring division step: shift in the next dividend bit and
   // subtract the modulus when the partial remainder reaches it.
   assign rem_shift = {rem_ff, mag_ff[WideW-1]};
   assign q_ext     = {1'b0, mod_ff};
   assign rem_diff  = rem_shift - q_ext;
   assign rem_in    = (rem_shift >= q_ext) ? rem_diff[ModW-1:0] : rem_shift[ModW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.abs_val) begin
         mag_ff <= mag_in;
         neg_ff <= s_ff[WideW-1];
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         mag_ff <= {mag_ff[WideW-2:0], 1'b0};
         rem_ff <= rem_in;
      end
   end

   // Division step counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.abs_val) begin
         cnt_ff <= '0;
      end else if (cmd.div_step) begin
         cnt_ff <= cnt_ff + CntW'(1);
      end
   end

   // Final residue: a negative value with nonzero remainder maps to q - r.
   // A zero modulus gives zero.
   always_comb begin
      if (mod_ff == '0) begin
         fix_val = '0;
      end else if (neg_ff && (rem_ff != '0)) begin
         fix_val = mod_ff - rem_ff;
      end else begin
         fix_val = rem_ff;
      end
   end

   // Running maximum of centered magnitudes; cleared after the last item.
   assign mag_narrow = mag_ff[CoeffW-1:0];
   assign max_in     = (mag_narrow > max_ff) ? mag_narrow : max_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= '0;
      end else if (cmd.norm) begin
         max_ff <= last_ff ? '0 : max_in;
      end
   end

   // Result of the current item.
   always_ff @(posedge clock) begin
      if (cmd.fix) begin
         res_ff <= {1'b0, fix_val};
      end else if (cmd.norm) begin
         res_ff <= max_in;
      end
   end

   // Output register; holds a result until the response transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_value_ff <= res_ff;
         rsp_last_ff  <= last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RspDataW-CoeffW){1'b0}}, rsp_value_ff};
   assign rsp_tlast  = rsp_last_ff;

   // Status toward the controller.
   assign sts.is_norm  = (kind_ff == KIND_NORM);
   assign sts.div_last = (cnt_ff == {CntW{1'b1}});
   assign sts.out_free = !rsp_valid_ff || rsp_tready;

endmodule

[rtl/mca_ctrl.sv]
// Controller of the modular coefficient unit: sequences preparation,
// division or norm update, and hand-off to the output register. Uses mca_pkg.
`include "assert_macros.svh"

module mca_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  mca_pkg::sts_type  sts,
   output mca_pkg::cmd_type  cmd
);
   import mca_pkg::*;

   state_type state_ff;
   state_type state_in;

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: state_in = ST_ABS;
         ST_ABS: begin
            state_in = sts.is_norm ? ST_NORM : ST_DIV;
         end
         ST_DIV: begin
            if (sts.div_last) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX:  state_in = ST_EMIT;
         ST_NORM: state_in = ST_EMIT;
         ST_EMIT: begin
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Command decode.
   assign req_tready   = (state_ff == ST_IDLE);
   assign cmd.load     = req_tready && req_tvalid;
   assign cmd.prep     = (state_ff == ST_PREP);
   assign cmd.abs_val  = (state_ff == ST_ABS);
   assign cmd.div_step = (state_ff == ST_DIV);
   assign cmd.fix      = (state_ff == ST_FIX);
   assign cmd.norm     = (state_ff == ST_NORM);
   assign cmd.emit     = (state_ff == ST_EMIT) && sts.out_free;

   // An accepted transfer always starts preparation next cycle.
   `ASSERT_CLK(a_accept_to_prep, clock, reset, cmd.load |=> state_ff == ST_PREP)
   // The divider runs until its counter reaches the final step.
   `ASSERT_CLK(a_div_holds, clock, reset,
      (state_ff == ST_DIV && !sts.div_last) |=> state_ff == ST_DIV)
   // A finished result waits while the output register is still occupied.
   `ASSERT_CLK(a_emit_waits, clock, reset,
      (state_ff == ST_EMIT && !sts.out_free) |=> state_ff == ST_EMIT)

endmodule
